FILE: hdl/kmst_pkg.sv
// Shared types for the Kruskal spanning tree block.
// Command and status words between controller and datapath.
// No dependencies.
package kmst_pkg;

    localparam int VTX_W = 6;   // vertex id field width
    localparam int VC_W  = 7;   // vertex_count register width

    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    typedef struct packed {
        logic in_take;
        logic init_we;
        logic scan_start;
        logic scan_issue;
        logic pick;
        logic find_a;
        logic find_b;
        logic union_we;
        logic union2_we;
        logic clear_run;
        logic emit_start;
        logic emit_ld;
        logic empty_ld;
    } kmst_cmd_t;

    typedef struct packed {
        logic init_done;
        logic pass_done;
        logic scan_last;
        logic best_found;
        logic best_oor;
        logic root_hit;
        logic roots_eq;
        logic rank_eq;
        logic tree_empty;
        logic emit_last;
        logic out_free;
    } kmst_sts_t;

endpackage

FILE: hdl/kmst_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/kmst_ctrl.sv
// Sequencer for load, init, selection scan, union-find and emit phases.
// Depends on kmst_pkg.
module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    input  kmst_sts_t sts,
    output kmst_cmd_t cmd
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_SST    = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SEND   = 4'd4;
    localparam logic [3:0] S_PICK   = 4'd5;
    localparam logic [3:0] S_FA     = 4'd6;
    localparam logic [3:0] S_FB     = 4'd7;
    localparam logic [3:0] S_UNION  = 4'd8;
    localparam logic [3:0] S_UNION2 = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_ER     = 4'd11;
    localparam logic [3:0] S_EW     = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_take = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_we = 1'b1;
                if (sts.init_done)
                begin
                    state_next = S_SST;
                end
            end
            S_SST:
            begin
                if (sts.pass_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (!sts.best_found)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = sts.best_oor ? S_SST : S_FA;
                end
            end
            S_FA:
            begin
                cmd.find_a = 1'b1;
                if (sts.root_hit)
                begin
                    state_next = S_FB;
                end
            end
            S_FB:
            begin
                cmd.find_b = 1'b1;
                if (sts.root_hit)
                begin
                    state_next = S_UNION;
                end
            end
            S_UNION:
            begin
                if (sts.roots_eq)
                begin
                    state_next = S_SST;
                end
                else
                begin
                    cmd.union_we = 1'b1;
                    state_next   = sts.rank_eq ? S_UNION2 : S_SST;
                end
            end
            S_UNION2:
            begin
                cmd.union2_we = 1'b1;
                state_next    = S_SST;
            end
            S_EMIT:
            begin
                if (sts.tree_empty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.empty_ld  = 1'b1;
                        cmd.clear_run = 1'b1;
                        state_next    = S_LOAD;
                    end
                end
                else
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_ER;
                end
            end
            S_ER:
            begin
                if (sts.out_free)
                begin
                    state_next = S_EW;
                end
            end
            S_EW:
            begin
                cmd.emit_ld = 1'b1;
                if (sts.emit_last)
                begin
                    cmd.clear_run = 1'b1;
                    state_next    = S_LOAD;
                end
                else
                begin
                    state_next = S_ER;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

FILE: hdl/kmst_dp.sv
// Datapath: edge store, selection scan, union-find table, tree store, output word.
// Depends on kmst_pkg and kmst_ram.
module kmst_dp
    import kmst_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmst_cmd_t                     cmd,
    output kmst_sts_t                     sts,
    input  logic [VC_W-1:0]               vertex_count,
    input  logic [VTX_W-1:0]              edge_src,
    input  logic [VTX_W-1:0]              edge_dst,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [VTX_W-1:0]              tree_src,
    output logic [VTX_W-1:0]              tree_dst,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          edge_valid,
    output logic                          last_result,
    output logic                          edges_dropped
);

    localparam int VB  = $clog2(MAX_VERTICES);
    localparam int EB  = $clog2(MAX_EDGES);
    localparam int EW  = 2 * VTX_W + WEIGHT_BITS;
    localparam int UW  = VB + 3;
    localparam logic [VB-1:0] V_LAST = VB'(MAX_VERTICES - 1);
    localparam logic [EB:0]   E_MAX  = (EB + 1)'(MAX_EDGES);
    localparam logic [VC_W-1:0] VC_MAX = VC_W'(MAX_VERTICES);

    // effective vertex count
    logic [VC_W-1:0] vc_eff;
    always_comb
    begin
        if (vertex_count == '0)
        begin
            vc_eff = VC_W'(1);
        end
        else if (vertex_count > VC_MAX)
        begin
            vc_eff = VC_MAX;
        end
        else
        begin
            vc_eff = vertex_count;
        end
    end

    logic [EB:0]            edge_count_reg;
    logic                   ovf_reg;
    logic [VB-1:0]          init_idx_reg;
    logic [EB-1:0]          scan_idx_reg;
    logic                   pend_reg;
    logic [EB-1:0]          pend_idx_reg;
    logic                   best_found_reg;
    logic [EB-1:0]          best_idx_reg;
    logic [EW-1:0]          best_edge_reg;
    logic                   prev_found_reg;
    logic [EB-1:0]          prev_idx_reg;
    logic [WEIGHT_BITS-1:0] prev_key_reg;
    logic [VB-1:0]          cur_v_reg;
    logic [VB-1:0]          ra_reg;
    logic [VB-1:0]          rb_reg;
    logic [2:0]             rka_reg;
    logic [2:0]             rkb_reg;
    logic [VB-1:0]          tree_count_reg;
    logic [VB-1:0]          emit_idx_reg;
    logic                   out_valid_reg;
    logic [EW-1:0]          out_edge_reg;
    logic                   edge_valid_reg;
    logic                   last_reg;
    logic                   drop_reg;

    // edge store
    logic          e_we;
    logic [EW-1:0] e_rdata;
    assign e_we = cmd.in_take && (edge_count_reg < E_MAX);

    kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (edge_count_reg[EB-1:0]),
        .wdata ({edge_src, edge_dst, edge_weight}),
        .raddr (scan_idx_reg),
        .rdata (e_rdata)
    );

    // union-find table: {parent, rank}
    logic          u_we;
    logic [VB-1:0] u_waddr;
    logic [UW-1:0] u_wdata;
    logic [VB-1:0] u_raddr;
    logic [UW-1:0] u_rdata;
    logic [VB-1:0] parent;
    logic [2:0]    rank;
    logic          root_hit;
    logic [VTX_W-1:0] b_src;
    logic [VTX_W-1:0] b_dst;

    assign parent   = u_rdata[UW-1:3];
    assign rank     = u_rdata[2:0];
    assign root_hit = (parent == cur_v_reg);
    assign b_src    = best_edge_reg[EW-1 -: VTX_W];
    assign b_dst    = best_edge_reg[EW-VTX_W-1 -: VTX_W];

    always_comb
    begin
        u_we    = 1'b0;
        u_waddr = init_idx_reg;
        u_wdata = {init_idx_reg, 3'd0};
        if (cmd.init_we)
        begin
            u_we = 1'b1;
        end
        else if (cmd.union_we)
        begin
            u_we = 1'b1;
            if (rka_reg < rkb_reg)
            begin
                u_waddr = ra_reg;
                u_wdata = {rb_reg, rka_reg};
            end
            else
            begin
                u_waddr = rb_reg;
                u_wdata = {ra_reg, rkb_reg};
            end
        end
        else if (cmd.union2_we)
        begin
            u_we    = 1'b1;
            u_waddr = ra_reg;
            u_wdata = {ra_reg, rka_reg + 3'd1};
        end
    end

    always_comb
    begin
        if (cmd.pick)
        begin
            u_raddr = b_src[VB-1:0];
        end
        else if (cmd.find_a && root_hit)
        begin
            u_raddr = b_dst[VB-1:0];
        end
        else
        begin
            u_raddr = parent;
        end
    end

    kmst_ram #(.WIDTH(UW), .DEPTH(MAX_VERTICES)) u_uf_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // tree store
    logic [EW-1:0] t_rdata;
    kmst_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tree_ram (
        .clk   (clk),
        .we    (cmd.union_we),
        .waddr (tree_count_reg),
        .wdata (best_edge_reg),
        .raddr (emit_idx_reg),
        .rdata (t_rdata)
    );

    // scan compare: smallest (key, index) above the previous pick
    logic [WEIGHT_BITS-1:0] cand_key;
    logic [WEIGHT_BITS-1:0] best_key;
    logic                   gt_prev;
    logic                   lt_best;
    assign cand_key = {~e_rdata[WEIGHT_BITS-1], e_rdata[WEIGHT_BITS-2:0]};
    assign best_key = {~best_edge_reg[WEIGHT_BITS-1], best_edge_reg[WEIGHT_BITS-2:0]};
    assign gt_prev  = !prev_found_reg || (cand_key > prev_key_reg) ||
                      ((cand_key == prev_key_reg) && (pend_idx_reg > prev_idx_reg));
    assign lt_best  = !best_found_reg || (cand_key < best_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            ovf_reg        <= 1'b0;
            init_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            prev_found_reg <= 1'b0;
            tree_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.in_take)
            begin
                init_idx_reg   <= '0;
                prev_found_reg <= 1'b0;
                tree_count_reg <= '0;
                if (edge_count_reg < E_MAX)
                begin
                    edge_count_reg <= edge_count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.init_we)
            begin
                init_idx_reg <= init_idx_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                best_found_reg <= 1'b0;
            end
            else if (pend_reg && gt_prev && lt_best)
            begin
                best_found_reg <= 1'b1;
            end
            pend_reg <= cmd.scan_issue;
            if (cmd.pick)
            begin
                prev_found_reg <= 1'b1;
            end
            if (cmd.union_we)
            begin
                tree_count_reg <= tree_count_reg + 1'b1;
            end
            if (cmd.clear_run)
            begin
                edge_count_reg <= '0;
                ovf_reg        <= 1'b0;
                tree_count_reg <= '0;
            end
            if (cmd.emit_ld || cmd.empty_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        pend_idx_reg <= scan_idx_reg;
        if (pend_reg && gt_prev && lt_best && !cmd.scan_start)
        begin
            best_idx_reg  <= pend_idx_reg;
            best_edge_reg <= e_rdata;
        end
        if (cmd.pick)
        begin
            prev_idx_reg <= best_idx_reg;
            prev_key_reg <= best_key;
            cur_v_reg    <= b_src[VB-1:0];
        end
        if (cmd.find_a)
        begin
            if (root_hit)
            begin
                ra_reg    <= cur_v_reg;
                rka_reg   <= rank;
                cur_v_reg <= b_dst[VB-1:0];
            end
            else
            begin
                cur_v_reg <= parent;
            end
        end
        if (cmd.find_b)
        begin
            if (root_hit)
            begin
                rb_reg  <= cur_v_reg;
                rkb_reg <= rank;
            end
            else
            begin
                cur_v_reg <= parent;
            end
        end
        if (cmd.emit_start)
        begin
            emit_idx_reg <= '0;
        end
        else if (cmd.emit_ld)
        begin
            emit_idx_reg <= emit_idx_reg + 1'b1;
        end
        if (cmd.emit_ld)
        begin
            out_edge_reg   <= t_rdata;
            edge_valid_reg <= 1'b1;
            last_reg       <= (emit_idx_reg == tree_count_reg - 1'b1);
            drop_reg       <= ovf_reg;
        end
        else if (cmd.empty_ld)
        begin
            out_edge_reg   <= '0;
            edge_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
            drop_reg       <= ovf_reg;
        end
    end

    always_comb
    begin
        sts.init_done  = (init_idx_reg == V_LAST);
        sts.pass_done  = ((VC_W'(tree_count_reg) + VC_W'(1)) >= vc_eff) ||
                         (edge_count_reg == '0);
        sts.scan_last  = ((EB + 1)'(scan_idx_reg) == edge_count_reg - 1'b1);
        sts.best_found = best_found_reg;
        sts.best_oor   = ({1'b0, b_src} >= vc_eff) || ({1'b0, b_dst} >= vc_eff);
        sts.root_hit   = root_hit;
        sts.roots_eq   = (ra_reg == rb_reg);
        sts.rank_eq    = (rka_reg == rkb_reg);
        sts.tree_empty = (tree_count_reg == '0);
        sts.emit_last  = (emit_idx_reg == tree_count_reg - 1'b1);
        sts.out_free   = !out_valid_reg;
    end

    assign out_valid     = out_valid_reg;
    assign tree_src      = out_edge_reg[EW-1 -: VTX_W];
    assign tree_dst      = out_edge_reg[EW-VTX_W-1 -: VTX_W];
    assign tree_weight   = out_edge_reg[WEIGHT_BITS-1:0];
    assign edge_valid    = edge_valid_reg;
    assign last_result   = last_reg;
    assign edges_dropped = drop_reg;

endmodule

FILE: hdl/kruskal_minimum_spanning_tree_top.sv
// Kruskal minimum spanning tree engine, top level.
// Depends on kmst_pkg, kmst_ctrl, kmst_dp (and kmst_ram through kmst_dp).
//
// Usage:
//   Input channel (in_valid/in_ready): one word per edge (edge_src, edge_dst,
//   edge_weight, last_edge). Edges load one per cycle. The word with
//   last_edge=1 closes the graph; in_ready then stays low until the whole
//   tree has been handed to the output register.
//   Output channel (out_valid/out_ready): one word per kept tree edge in
//   ascending weight order (arrival order on ties), last_result on the final
//   word; an empty tree gives a single word with edge_valid=0.
//   edges_dropped flags a graph that overflowed the MAX_EDGES edge store.
//   Config: APB register 0 (byte address 0) is vertex_count, 7 bits.
// Run sequence after the last edge:
//   the union-find table is set up for all MAX_VERTICES vertices, then one
//   selection pass runs per visited edge (each pass scans all stored edges
//   through the edge RAM's single read port), plus, for an edge inside
//   vertex_count, the root walks of both endpoints and up to two union
//   writes. Emit moves the tree words to the output register one at a time
//   and waits while the receiver holds the previous word.
// Reset: rst_n clears edge/init/tree counters, output valid; vertex_count to 64.
// A stalled receiver holds the output word; the block waits for it.
module kruskal_minimum_spanning_tree_top
    import kmst_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [VTX_W-1:0]              edge_src,
    input  logic [VTX_W-1:0]              edge_dst,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic                          last_edge,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [VTX_W-1:0]              tree_src,
    output logic [VTX_W-1:0]              tree_dst,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          edge_valid,
    output logic                          last_result,
    output logic                          edges_dropped
);

    // vertex_count register; only register index 0 exists
    logic [VC_W-1:0] vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            vc_reg <= pwdata[VC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - VC_W){1'b0}}, vc_reg} : 32'd0;

    kmst_cmd_t cmd;
    kmst_sts_t sts;

    kmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_edge),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kmst_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .vertex_count  (vc_reg),
        .edge_src      (edge_src),
        .edge_dst      (edge_dst),
        .edge_weight   (edge_weight),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tree_src      (tree_src),
        .tree_dst      (tree_dst),
        .tree_weight   (tree_weight),
        .edge_valid    (edge_valid),
        .last_result   (last_result),
        .edges_dropped (edges_dropped)
    );

`ifndef SYNTH
    // graph closed: no more edges taken until the run finishes
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_edge |=> !in_ready)
        else $error("edge taken right after closing word");

    // empty-tree word is always the final word
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_valid |-> last_result)
        else $error("empty-tree word without last_result");

    // while a non-final tree word waits, the input stays closed
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
        else $error("input open during emit");
`endif

endmodule

FILE: bench/tb.sv
// Self-checking bench for the Kruskal spanning tree engine.
// Depends on kmst_pkg and kruskal_minimum_spanning_tree_top.
`timescale 1ns / 100ps

module tb;
    import kmst_pkg::*;

    localparam int NV = 64;
    localparam int NE = 256;
    localparam int WB = 16;
    localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

    typedef struct packed {
        logic [5:0]     src;
        logic [5:0]     dst;
        logic [WB-1:0]  weight;
        logic           last;
    } edge_word_t;

    typedef struct packed {
        logic [5:0]     src;
        logic [5:0]     dst;
        logic [WB-1:0]  weight;
        logic           valid;
        logic           last;
        logic           dropped;
    } tree_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [5:0] edge_src = '0, edge_dst = '0;
    logic signed [WB-1:0] edge_weight = '0;
    logic last_edge = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [5:0] tree_src, tree_dst;
    logic signed [WB-1:0] tree_weight;
    logic edge_valid, last_result, edges_dropped;

    kruskal_minimum_spanning_tree_top uut (.*);

    always #5 clk = ~clk;

    // Predictor state: its own copy of the edge store and the register.
    edge_word_t  pending_words[$];
    tree_word_t  expected_tree[$];
    edge_word_t  graph_edges[$];
    logic        graph_overflow;
    int          vc_setting = 64;
    int          fail_count = 0;
    bit          calm = 1'b0;    // stretch with no idling on either side

    // Kruskal over the collected graph; pushes the expected tree words.
    task automatic predict_tree();
        edge_word_t sorted[$];
        edge_word_t e;
        tree_word_t t;
        int parent[NV];
        int rnk[NV];
        int vc, j, ra, rb, kept;
        sorted = graph_edges;
        // stable insertion sort on signed weight
        for (int i = 1; i < sorted.size(); i++) begin
            e = sorted[i];
            j = i;
            while (j > 0 && $signed(sorted[j-1].weight) > $signed(e.weight)) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = e;
        end
        vc = (vc_setting < 1) ? 1 : (vc_setting > NV ? NV : vc_setting);
        for (int i = 0; i < NV; i++) begin
            parent[i] = i;
            rnk[i] = 0;
        end
        kept = 0;
        for (int i = 0; i < sorted.size() && kept + 1 < vc; i++) begin
            if (sorted[i].src >= vc || sorted[i].dst >= vc)
                continue;
            ra = sorted[i].src;
            while (parent[ra] != ra) ra = parent[ra];
            rb = sorted[i].dst;
            while (parent[rb] != rb) rb = parent[rb];
            if (ra != rb) begin
                t = '{sorted[i].src, sorted[i].dst, sorted[i].weight, 1'b1, 1'b0,
                      graph_overflow};
                expected_tree.push_back(t);
                kept++;
                if (rnk[ra] < rnk[rb]) parent[ra] = rb;
                else if (rnk[ra] > rnk[rb]) parent[rb] = ra;
                else
                begin
                    parent[rb] = ra;
                    rnk[ra] = (rnk[ra] + 1) & 7;
                end
            end
        end
        if (kept == 0)
            expected_tree.push_back('{6'd0, 6'd0, '0, 1'b0, 1'b1, graph_overflow});
        else
            expected_tree[expected_tree.size()-1].last = 1'b1;
        graph_edges.delete();
        graph_overflow = 1'b0;
    endtask

    // Driver: holds valid until accepted, random idles between words.
    always @(posedge clk)
    begin
        edge_word_t w;
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 27))
                begin
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    edge_src <= w.src;
                    edge_dst <= w.dst;
                    edge_weight <= w.weight;
                    last_edge <= w.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Accepted input words feed the predictor.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (graph_edges.size() < NE)
                graph_edges.push_back('{edge_src, edge_dst, edge_weight, last_edge});
            else
                graph_overflow = 1'b1;
            if (last_edge)
                predict_tree();
        end
    end

    // Monitor: random back-pressure, compare each accepted result word.
    always @(posedge clk)
    begin
        tree_word_t exp_w;
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(99) >= 27);
            if (out_valid && out_ready)
            begin
                if (expected_tree.size() == 0)
                begin
                    $display("%0t: unexpected result src=%0d dst=%0d w=%0d", $time,
                             tree_src, tree_dst, tree_weight);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_tree.pop_front();
                    if ({tree_src, tree_dst, tree_weight, edge_valid, last_result,
                         edges_dropped} !== exp_w)
                    begin
                        $display("%0t: mismatch expected %0d %0d %0d v%0b l%0b d%0b",
                                 $time, exp_w.src, exp_w.dst, $signed(exp_w.weight),
                                 exp_w.valid, exp_w.last, exp_w.dropped);
                        $display("%0t:          actual %0d %0d %0d v%0b l%0b d%0b",
                                 $time, tree_src, tree_dst, tree_weight, edge_valid,
                                 last_result, edges_dropped);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic write_vertex_count(input int value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_VERTEX_COUNT;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        vc_setting = value & 7'h7f;
    endtask

    // Queue one graph of random edges with vertex ids from 0 to vmax.
    task automatic add_graph(input int n, input int vmax, input int wspan);
        edge_word_t w;
        for (int i = 0; i < n; i++) begin
            w.src = 6'($urandom_range(vmax));
            w.dst = 6'($urandom_range(vmax));
            w.weight = (wspan == 0) ? WB'($urandom) : WB'($urandom_range(wspan));
            w.last = (i == n - 1);
            pending_words.push_back(w);
        end
    endtask

    // Wait for the queued graphs to drain, then a latency pause.
    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid);
        wait (expected_tree.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        graph_overflow = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, self loop, ties, single edge
        pending_words.push_back('{6'd0, 6'd63, 16'sh7fff, 1'b0});
        pending_words.push_back('{6'd63, 6'd0, 16'sh8000, 1'b0});
        pending_words.push_back('{6'd5, 6'd5, 16'sh0000, 1'b0});
        pending_words.push_back('{6'd1, 6'd2, 16'sh0003, 1'b0});
        pending_words.push_back('{6'd2, 6'd3, 16'sh0003, 1'b0});
        pending_words.push_back('{6'd1, 6'd3, 16'sh0003, 1'b0});
        pending_words.push_back('{6'd42, 6'd21, 16'shffff, 1'b1});
        pending_words.push_back('{6'd7, 6'd7, 16'sh1234, 1'b1});   // empty tree
        drain();
        write_vertex_count(1);     // tree always empty
        pending_words.push_back('{6'd0, 6'd0, 16'sh0001, 1'b0});
        pending_words.push_back('{6'd0, 6'd1, 16'sh0002, 1'b1});
        drain();
        write_vertex_count(0);     // treated as one
        pending_words.push_back('{6'd0, 6'd1, 16'sh0002, 1'b1});
        drain();
        write_vertex_count(127);   // clamps to 64
        add_graph(6, 63, 0);
        drain();
        write_vertex_count(4);     // endpoints beyond 3 skipped
        add_graph(8, 7, 3);
        drain();

        // overflow: a store full of small weights plus a dropped last word,
        // run as the long stretch with no idling
        write_vertex_count(8);
        calm = 1'b1;
        add_graph(NE + 1, 9, 15);
        drain();
        calm = 1'b0;

        // random graphs, mostly small
        sent = 0;
        while (sent < 70) begin
            int n;
            if (sent % 60 == 0)
            begin
                drain();
                write_vertex_count($urandom_range(2, 64));
            end
            n = $urandom_range(1, 10);
            add_graph(n, $urandom_range(1, 63), ($urandom_range(1) ? 0 : 7));
            sent += n;
        end
        drain();
        write_vertex_count(64);
        add_graph(12, 63, 0);
        drain();

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end
endmodule

FILE: sim.f
hdl/kmst_pkg.sv
hdl/kmst_ram.sv
hdl/kmst_ctrl.sv
hdl/kmst_dp.sv
hdl/kruskal_minimum_spanning_tree_top.sv
bench/tb.sv
